FILE: rtl/gktrq_pkg.sv
// shared types, constants and tables for the gamepad key qualifier
package gktrq_pkg;

	localparam int KEY_COUNT_DEF  = 20;
	localparam int TIMER_BITS_DEF = 24;
	localparam int KEY_W          = 20;
	localparam int BUTTON_W       = 16;
	localparam int BUTTON_KEYS    = 14;
	localparam int TRIG_W         = 8;
	localparam int STICK_W        = 16;
	localparam int STICK_LVL_W    = 15;
	localparam int ELAPSED_W      = 20;
	localparam int CFG_TIME_W     = 24;
	localparam int PADDR_W        = 5;
	localparam int PDATA_W        = 32;

	// key positions of the analog keys
	localparam int KEY_LT  = 14;
	localparam int KEY_RT  = 15;
	localparam int KEY_LSR = 16;
	localparam int KEY_LSL = 17;
	localparam int KEY_RSR = 18;
	localparam int KEY_RSL = 19;

	localparam logic [CFG_TIME_W-1:0]  DBL_WINDOW_RST  = CFG_TIME_W'(300000);
	localparam logic [CFG_TIME_W-1:0]  FIRST_DELAY_RST = CFG_TIME_W'(500000);
	localparam logic [CFG_TIME_W-1:0]  PERIOD_RST      = CFG_TIME_W'(100000);
	localparam logic [TRIG_W-1:0]      TRIG_LVL_RST    = TRIG_W'(230);
	localparam logic [STICK_LVL_W-1:0] STICK_LVL_RST   = STICK_LVL_W'(10000);

	typedef enum logic [PADDR_W-3:0] {
		REG_DBL_WINDOW  = 3'd0,
		REG_FIRST_DELAY = 3'd1,
		REG_PERIOD      = 3'd2,
		REG_TRIG_LVL    = 3'd3,
		REG_STICK_LVL   = 3'd4
	} cfg_reg_t;

	// button word mask for each of the digital keys, key 0 first
	localparam logic [BUTTON_W-1:0] BUTTON_MASK [BUTTON_KEYS] = '{
		16'h1000, 16'h0002, 16'h2000, 16'h0008, 16'h4000, 16'h0004, 16'h8000,
		16'h0001, 16'h0100, 16'h0200, 16'h0040, 16'h0080, 16'h0010, 16'h0020
	};

	typedef struct packed {
		logic [CFG_TIME_W-1:0]  dbl_window;
		logic [CFG_TIME_W-1:0]  first_delay;
		logic [CFG_TIME_W-1:0]  period;
		logic [TRIG_W-1:0]      trig_lvl;
		logic [STICK_LVL_W-1:0] stick_lvl;
	} cfg_t;

	typedef struct packed {
		logic down;
		logic tapped;
		logic released;
		logic dbl;
		logic rep;
	} lane_out_t;

endpackage

FILE: rtl/gktrq_poll_if.sv
// poll snapshot channel
interface gktrq_poll_if import gktrq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [BUTTON_W-1:0]        button_bits;
	logic [TRIG_W-1:0]          left_trigger;
	logic [TRIG_W-1:0]          right_trigger;
	logic signed [STICK_W-1:0]  left_stick_x;
	logic signed [STICK_W-1:0]  right_stick_x;
	logic [ELAPSED_W-1:0]       elapsed_us;
	logic                       pad_connected;

	modport source (
		output valid, button_bits, left_trigger, right_trigger,
		output left_stick_x, right_stick_x, elapsed_us, pad_connected,
		input  ready
	);
	modport sink (
		input  valid, button_bits, left_trigger, right_trigger,
		input  left_stick_x, right_stick_x, elapsed_us, pad_connected,
		output ready
	);
endinterface

FILE: rtl/gktrq_keys_if.sv
// qualified key result channel
interface gktrq_keys_if import gktrq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] down_keys;
	logic [KEY_W-1:0] tapped_keys;
	logic [KEY_W-1:0] released_keys;
	logic [KEY_W-1:0] double_tapped_keys;
	logic [KEY_W-1:0] repeat_keys;

	modport source (
		output valid, down_keys, tapped_keys, released_keys,
		output double_tapped_keys, repeat_keys,
		input  ready
	);
	modport sink (
		input  valid, down_keys, tapped_keys, released_keys,
		input  double_tapped_keys, repeat_keys,
		output ready
	);
endinterface

FILE: rtl/gktrq_keymap.sv
// maps a raw gamepad snapshot onto the key bit vector
module gktrq_keymap import gktrq_pkg::*; (
	input  logic [BUTTON_W-1:0]       button_bits,
	input  logic [TRIG_W-1:0]         left_trigger,
	input  logic [TRIG_W-1:0]         right_trigger,
	input  logic signed [STICK_W-1:0] left_stick_x,
	input  logic signed [STICK_W-1:0] right_stick_x,
	input  cfg_t                      cfg,
	output logic [KEY_W-1:0]          keys
);
	logic signed [STICK_W-1:0] lvl_pos;
	logic signed [STICK_W-1:0] lvl_neg;

	assign lvl_pos = signed'({1'b0, cfg.stick_lvl});
	assign lvl_neg = -lvl_pos;

	always_comb begin
		for (int i = 0; i < BUTTON_KEYS; i++) begin
			keys[i] = |(button_bits & BUTTON_MASK[i]);
		end
		keys[KEY_LT]  = left_trigger > cfg.trig_lvl;
		keys[KEY_RT]  = right_trigger > cfg.trig_lvl;
		keys[KEY_LSR] = left_stick_x > lvl_pos;
		keys[KEY_LSL] = left_stick_x < lvl_neg;
		keys[KEY_RSR] = right_stick_x > lvl_pos;
		keys[KEY_RSL] = right_stick_x < lvl_neg;
	end
endmodule

FILE: rtl/gktrq_lane.sv
// per-key tap, double-tap and auto-repeat tracker
module gktrq_lane import gktrq_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 connected,
	input  logic                 key_raw,
	input  logic [ELAPSED_W-1:0] elapsed,
	input  cfg_t                 cfg,
	output lane_out_t            res
);
	localparam int SW = ((TIMER_BITS > ELAPSED_W) ? TIMER_BITS : ELAPSED_W) + 1;
	localparam int CW = (TIMER_BITS > CFG_TIME_W) ? TIMER_BITS : CFG_TIME_W;

	logic [TIMER_BITS-1:0] since_q, hold_q;
	logic                  pend_q, cur_q, dbl_q, rep_q;

	logic [SW-1:0]         tmax_w, since_sum, hold_sum;
	logic [TIMER_BITS-1:0] since_sat, hold_sat, since_d, hold_d;
	logic [CFG_TIME_W-1:0] limit;
	logic                  cur_d, tap, held, in_window, fire;
	logic                  pend_d, dbl_d, rep_d;

	assign tmax_w    = SW'({TIMER_BITS{1'b1}});
	assign since_sum = SW'(since_q) + SW'(elapsed);
	assign hold_sum  = SW'(hold_q) + SW'(elapsed);
	assign since_sat = (since_sum > tmax_w) ? {TIMER_BITS{1'b1}} : since_sum[TIMER_BITS-1:0];
	assign hold_sat  = (hold_sum > tmax_w) ? {TIMER_BITS{1'b1}} : hold_sum[TIMER_BITS-1:0];

	assign cur_d     = connected & key_raw;
	assign tap       = cur_d & ~cur_q;
	assign held      = cur_d & cur_q;
	assign in_window = CW'(since_sat) <= CW'(cfg.dbl_window);
	assign limit     = pend_q ? cfg.first_delay : cfg.period;
	assign fire      = CW'(hold_sat) > CW'(limit);

	always_comb begin
		since_d = tap ? '0 : since_sat;
		hold_d  = hold_q;
		pend_d  = pend_q;
		dbl_d   = dbl_q;
		rep_d   = rep_q;
		if (connected) begin
			dbl_d = tap & in_window;
			rep_d = tap | (held & fire);
			if (tap) begin
				hold_d = '0;
				pend_d = 1'b1;
			end else if (held) begin
				hold_d = fire ? '0 : hold_sat;
				pend_d = pend_q & ~fire;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q <= '1;
			hold_q  <= '0;
			pend_q  <= 1'b0;
			cur_q   <= 1'b0;
			dbl_q   <= 1'b0;
			rep_q   <= 1'b0;
		end else if (step) begin
			since_q <= since_d;
			hold_q  <= hold_d;
			pend_q  <= pend_d;
			cur_q   <= cur_d;
			dbl_q   <= dbl_d;
			rep_q   <= rep_d;
		end
	end

	assign res.down     = cur_d;
	assign res.tapped   = tap;
	assign res.released = cur_q & ~cur_d;
	assign res.dbl      = dbl_d;
	assign res.rep      = rep_d;
endmodule

FILE: rtl/gktrq_merge.sv
// gathers the lane results into one output beat register
module gktrq_merge import gktrq_pkg::*; #(
	parameter int LANES = KEY_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  lane_out_t lanes [LANES],
	gktrq_keys_if.source keys
);
	logic             valid_q;
	logic [KEY_W-1:0] down_s1, tapped_s1, released_s1, dbl_s1, rep_s1;
	logic [KEY_W-1:0] down_w, tapped_w, released_w, dbl_w, rep_w;

	// keys past the lane count stay up
	always_comb begin
		down_w     = '0;
		tapped_w   = '0;
		released_w = '0;
		dbl_w      = '0;
		rep_w      = '0;
		for (int i = 0; i < LANES; i++) begin
			down_w[i]     = lanes[i].down;
			tapped_w[i]   = lanes[i].tapped;
			released_w[i] = lanes[i].released;
			dbl_w[i]      = lanes[i].dbl;
			rep_w[i]      = lanes[i].rep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (keys.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			down_s1     <= down_w;
			tapped_s1   <= tapped_w;
			released_s1 <= released_w;
			dbl_s1      <= dbl_w;
			rep_s1      <= rep_w;
		end
	end

	assign keys.valid              = valid_q;
	assign keys.down_keys          = down_s1;
	assign keys.tapped_keys        = tapped_s1;
	assign keys.released_keys      = released_s1;
	assign keys.double_tapped_keys = dbl_s1;
	assign keys.repeat_keys        = rep_s1;
endmodule

FILE: rtl/gamepad_key_tap_repeat_qualifier.sv
// top level of the gamepad key tap, double-tap and auto-repeat qualifier
//
//  channel   dir  handshake              payload
//  poll      in   valid / ready          buttons, triggers, stick x, elapsed_us, connected
//  keys      out  valid / ready          down, tapped, released, double-tapped, repeat
//  apb       in   psel/penable/pready    five timing and level registers
//
// one poll beat is taken per cycle while keys is not stalled; its result beat is valid
// the cycle after acceptance, set by the single output register behind the lane array
// poll.ready stays high while the output register is empty or being drained
// a stalled keys channel holds one finished beat and stops further polls
// reset clears every lane: tap timers saturated, hold timers zero, keys up
// registers return to their default levels at reset and are read back over apb
module gamepad_key_tap_repeat_qualifier import gktrq_pkg::*; #(
	parameter int KEY_COUNT  = KEY_COUNT_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	gktrq_poll_if.sink          poll,
	gktrq_keys_if.source        keys
);
	// keys beyond the twentieth never press, so no lane is built for them
	localparam int LANES = (KEY_COUNT < KEY_W) ? KEY_COUNT : KEY_W;

	cfg_t             cfg_q;
	logic             cfg_wr;
	logic             step;
	logic [KEY_W-1:0] raw_keys;
	lane_out_t        lane_res [LANES];

	// ---- register port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dbl_window  <= DBL_WINDOW_RST;
			cfg_q.first_delay <= FIRST_DELAY_RST;
			cfg_q.period      <= PERIOD_RST;
			cfg_q.trig_lvl    <= TRIG_LVL_RST;
			cfg_q.stick_lvl   <= STICK_LVL_RST;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(paddr[PADDR_W-1:2]))
				REG_DBL_WINDOW:  cfg_q.dbl_window  <= pwdata[CFG_TIME_W-1:0];
				REG_FIRST_DELAY: cfg_q.first_delay <= pwdata[CFG_TIME_W-1:0];
				REG_PERIOD:      cfg_q.period      <= pwdata[CFG_TIME_W-1:0];
				REG_TRIG_LVL:    cfg_q.trig_lvl    <= pwdata[TRIG_W-1:0];
				REG_STICK_LVL:   cfg_q.stick_lvl   <= pwdata[STICK_LVL_W-1:0];
				default: ; // unmapped addresses drop the write
			endcase
		end
	end

	always_comb begin
		case (cfg_reg_t'(paddr[PADDR_W-1:2]))
			REG_DBL_WINDOW:  prdata = PDATA_W'(cfg_q.dbl_window);
			REG_FIRST_DELAY: prdata = PDATA_W'(cfg_q.first_delay);
			REG_PERIOD:      prdata = PDATA_W'(cfg_q.period);
			REG_TRIG_LVL:    prdata = PDATA_W'(cfg_q.trig_lvl);
			REG_STICK_LVL:   prdata = PDATA_W'(cfg_q.stick_lvl);
			default:         prdata = '0;
		endcase
	end

	// ---- poll handshake: take a beat whenever the output slot frees up
	assign poll.ready = ~keys.valid | keys.ready;
	assign step       = poll.valid & poll.ready;

	// ---- snapshot to key bits
	gktrq_keymap u_keymap (
		.button_bits   (poll.button_bits),
		.left_trigger  (poll.left_trigger),
		.right_trigger (poll.right_trigger),
		.left_stick_x  (poll.left_stick_x),
		.right_stick_x (poll.right_stick_x),
		.cfg           (cfg_q),
		.keys          (raw_keys)
	);

	// ---- one tracker lane per key, all working on the same beat
	for (genvar k = 0; k < LANES; k++) begin : g_lane
		gktrq_lane #(
			.TIMER_BITS (TIMER_BITS)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (step),
			.connected (poll.pad_connected),
			.key_raw   (raw_keys[k]),
			.elapsed   (poll.elapsed_us),
			.cfg       (cfg_q),
			.res       (lane_res[k])
		);
	end

	// ---- lane results into the output beat
	gktrq_merge #(
		.LANES (LANES)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.lanes  (lane_res),
		.keys   (keys)
	);

`ifndef SYNTHESIS
	// a key cannot be both newly pressed and newly released, and a tap is down
	a_tap_release: assert property (@(posedge clk) disable iff (!arst_n)
		keys.valid |-> (((keys.tapped_keys & keys.released_keys) == '0) &&
		((keys.tapped_keys & ~keys.down_keys) == '0)))
		else $error("tapped key also released or not down");

	// every tap fires a repeat in the same beat
	a_tap_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		keys.valid |-> ((keys.tapped_keys & ~keys.repeat_keys) == '0))
		else $error("tapped key without repeat flag");

	// an accepted poll always leaves a result beat pending
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		(poll.valid && poll.ready) |=> keys.valid)
		else $error("accepted poll produced no result beat");
`endif
endmodule
